[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, suspended while reset is held
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, suspended while reset is held
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/mbet_pkg.sv]
`timescale 1ns / 1ps

package mbet_pkg;

  // Coordinate word: signed fixed point, FRAC_BITS fraction bits
  localparam int WORD_W     = 48;
  localparam int HALF_W     = WORD_W / 2;
  localparam int FRAC_BITS  = 44;

  // Iteration counter width (default for the top-level parameter)
  localparam int COUNT_BITS = 16;

  // Image bounds used to clamp out-of-range pixel positions
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  // Field widths
  localparam int COL_W   = 12;
  localparam int ROW_W   = 12;
  localparam int LIMIT_W = 16;
  localparam int ESC_W   = 16;
  localparam int CHAN_W  = 8;

  // Stream payload layout
  localparam int IN_DATA_W  = COL_W + ROW_W;
  localparam int OUT_DATA_W = ESC_W + 2 * CHAN_W;
  localparam int RED_LSB    = ESC_W;
  localparam int GREEN_LSB  = ESC_W + CHAN_W;

  // Configuration register map
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RE_LEFT,
    REG_IM_TOP,
    REG_RE_STEP,
    REG_IM_STEP,
    REG_ITER_LIMIT
  } cfg_reg_t;

  // Register reset values: -1.9, 1.3, 2.6/1920, 2.6/1080 and 255
  localparam logic signed [WORD_W-1:0] RE_LEFT_RST = -48'sd33425153484390;
  localparam logic signed [WORD_W-1:0] IM_TOP_RST  = 48'sd22869841857741;
  localparam logic signed [WORD_W-1:0] RE_STEP_RST = 48'sd23822751935;
  localparam logic signed [WORD_W-1:0] IM_STEP_RST = 48'sd42351558996;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST   = 16'd255;

endpackage

[hw/rtl/mandelbrot_escape_time_pixel_core.sv]
// Channel   Ports            Payload (lowest bit first)
// input     in_tvalid/ready  in_tdata:  column[11:0], row[23:12]
// result    out_tvalid/ready out_tdata: escape_count[15:0], red[23:16], green[31:24]
// config    cfg_wr_en        cfg_addr selects the register, cfg_wdata[47:0]
//
// One 25x25 signed multiplier is shared by every product; a 48x48 product takes four
// partial products, accumulated in turn. A pixel first computes c_re and c_im, then
// runs iterations (squares of z_re and z_im, then the cross product) until it escapes
// or reaches the iteration limit, and then posts the result.
// in_tready is high only while the core is idle; a finished result waits in the
// output register, so the next pixel may be taken while it is still held.
// Reset (rst_n low at a clock edge) returns to idle, drops the result and reloads
// the register defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_core #(
  parameter int COUNT_BITS = mbet_pkg::COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: column, row
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mbet_pkg::IN_DATA_W-1:0]   in_tdata,
  // out_tdata: escape_count, red, green
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mbet_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [mbet_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mbet_pkg::WORD_W-1:0]      cfg_wdata
);

  localparam int WORD_W   = mbet_pkg::WORD_W;
  localparam int HALF_W   = mbet_pkg::HALF_W;
  localparam int FRAC     = mbet_pkg::FRAC_BITS;
  localparam int PP_W     = 2 * HALF_W + 2;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int COL_W    = mbet_pkg::COL_W;
  localparam int ROW_W    = mbet_pkg::ROW_W;
  localparam int CHAN_W   = mbet_pkg::CHAN_W;
  localparam int LIMIT_W  = mbet_pkg::LIMIT_W;
  localparam int LW       = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int COL_LAST = mbet_pkg::MAX_COLUMNS - 1;
  localparam int ROW_LAST = mbet_pkg::MAX_ROWS - 1;

  localparam logic [LW-1:0] COUNT_MAX = LW'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [2:0]    MSTEP_LAST = 3'd4;
  // Escape threshold: 16 in the fixed-point scale of the squares
  localparam logic signed [SUM_W-1:0] THRESH =
    {{(SUM_W - FRAC - 5){1'b0}}, 5'b10000, {FRAC{1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_POST, S_CHECK, S_COLOUR} state_t;
  typedef enum logic [2:0] {J_C_RE, J_C_IM, J_SQ_RE, J_SQ_IM, J_CROSS} job_t;

  // Clamp a wide sum into the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v[SUM_W-1:WORD_W-1] == {(SUM_W - WORD_W + 1){v[SUM_W-1]}}) begin
      r = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(WORD_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W - 1){1'b1}}};
    end
    return r;
  endfunction

  // Remainder modulo 255 of a 16-bit value: fold bytes, since 256 is 1 mod 255
  function automatic logic [CHAN_W-1:0] mod255(input logic [2*CHAN_W-1:0] v);
    logic [CHAN_W:0] s;
    logic [CHAN_W:0] t;
    s = {1'b0, v[2*CHAN_W-1:CHAN_W]} + {1'b0, v[CHAN_W-1:0]};
    t = {{CHAN_W{1'b0}}, s[CHAN_W]} + {1'b0, s[CHAN_W-1:0]};
    return (t[CHAN_W-1:0] == {CHAN_W{1'b1}}) ? '0 : t[CHAN_W-1:0];
  endfunction

  // Registers
  state_t                     state_r, state_nxt;
  job_t                       job_r, job_nxt;
  logic [2:0]                 mstep_r, mstep_nxt;
  logic signed [WORD_W-1:0]   op_a_r, op_a_nxt;
  logic signed [WORD_W-1:0]   op_b_r, op_b_nxt;
  logic signed [PP_W-1:0]     pp_r, pp_nxt;
  logic [1:0]                 pp_sh_r, pp_sh_nxt;
  logic signed [PROD_W-1:0]   acc_r, acc_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic signed [WORD_W-1:0]   c_re_r, c_re_nxt;
  logic signed [WORD_W-1:0]   c_im_r, c_im_nxt;
  logic signed [WORD_W-1:0]   zr_r, zr_nxt;
  logic signed [WORD_W-1:0]   zi_r, zi_nxt;
  logic signed [PROD_W-1:0]   sq_re_r, sq_re_nxt;
  logic signed [PROD_W-1:0]   sq_im_r, sq_im_nxt;
  logic [COUNT_BITS-1:0]      count_r, count_nxt;
  logic [CHAN_W-1:0]          red_r, red_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [mbet_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic signed [WORD_W-1:0]   re_left_r, re_left_nxt;
  logic signed [WORD_W-1:0]   im_top_r, im_top_nxt;
  logic signed [WORD_W-1:0]   re_step_r, re_step_nxt;
  logic signed [WORD_W-1:0]   im_step_r, im_step_nxt;
  logic [LIMIT_W-1:0]         limit_r, limit_nxt;

  // Datapath wires
  logic [COL_W-1:0]           col_in, col_clamp;
  logic [ROW_W-1:0]           row_in, row_clamp;
  logic signed [HALF_W:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0]   pp_ext, pp_shifted;
  logic signed [PROD_W-1:0]   sq_now;
  logic signed [PROD_W:0]     dbl_prod, cross_now;
  logic signed [SUM_W-1:0]    sq_sum, c_re_sum, c_im_sum, zr_sum, zi_sum;
  logic [LW-1:0]              limit_ext, limit_eff;
  logic                       go_on, escaped;
  logic [2*CHAN_W-1:0]        red_sq;
  logic [mbet_pkg::ESC_W-1:0] escape_count;

  // Clamp pixel position to the image
  assign col_in    = in_tdata[COL_W-1:0];
  assign row_in    = in_tdata[COL_W +: ROW_W];
  assign col_clamp = (int'(col_in) > COL_LAST) ? COL_W'(COL_LAST) : col_in;
  assign row_clamp = (int'(row_in) > ROW_LAST) ? ROW_W'(ROW_LAST) : row_in;

  // Shared multiplier: one signed 25x25 partial product per cycle
  assign mul_a = mstep_r[1] ? {op_a_r[WORD_W-1], op_a_r[WORD_W-1:HALF_W]}
                            : {1'b0, op_a_r[HALF_W-1:0]};
  assign mul_b = mstep_r[0] ? {op_b_r[WORD_W-1], op_b_r[WORD_W-1:HALF_W]}
                            : {1'b0, op_b_r[HALF_W-1:0]};
  assign pp_nxt    = mul_a * mul_b;
  assign pp_sh_nxt = {1'b0, mstep_r[1]} + {1'b0, mstep_r[0]};
  assign pp_ext    = PROD_W'(pp_r);

  // Align the registered partial product to its weight
  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext <<< HALF_W;
      default: pp_shifted = pp_ext <<< (2 * HALF_W);
    endcase
  end

  // Post-product arithmetic
  assign sq_now    = acc_r >>> FRAC;
  assign dbl_prod  = {acc_r, 1'b0};
  assign cross_now = dbl_prod >>> FRAC;
  assign sq_sum    = SUM_W'(sq_re_r) + SUM_W'(sq_now);
  assign escaped   = !(sq_sum < THRESH);
  assign c_re_sum  = SUM_W'(re_left_r) + SUM_W'(acc_r);
  assign c_im_sum  = SUM_W'(im_top_r) - SUM_W'(acc_r);
  assign zr_sum    = SUM_W'(sq_re_r) - SUM_W'(sq_im_r) + SUM_W'(c_re_r);
  assign zi_sum    = SUM_W'(cross_now) + SUM_W'(c_im_r);

  // Iteration bound
  assign limit_ext = LW'(limit_r);
  assign limit_eff = (limit_ext > COUNT_MAX) ? COUNT_MAX : limit_ext;
  assign go_on     = LW'(count_r) < limit_eff;

  // Colour channels
  assign red_sq       = {{CHAN_W{1'b0}}, red_r} * {{CHAN_W{1'b0}}, red_r};
  assign escape_count = mbet_pkg::ESC_W'(count_r);

  // Sequencer and register updates
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    mstep_nxt     = mstep_r;
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    acc_nxt       = acc_r;
    row_nxt       = row_r;
    c_re_nxt      = c_re_r;
    c_im_nxt      = c_im_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    sq_re_nxt     = sq_re_r;
    sq_im_nxt     = sq_im_r;
    count_nxt     = count_r;
    red_nxt       = red_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    re_left_nxt   = re_left_r;
    im_top_nxt    = im_top_r;
    re_step_nxt   = re_step_r;
    im_step_nxt   = im_step_r;
    limit_nxt     = limit_r;

    // Configuration writes
    if (cfg_wr_en) begin
      case (cfg_addr)
        mbet_pkg::REG_RE_LEFT:    re_left_nxt = cfg_wdata;
        mbet_pkg::REG_IM_TOP:     im_top_nxt  = cfg_wdata;
        mbet_pkg::REG_RE_STEP:    re_step_nxt = cfg_wdata;
        mbet_pkg::REG_IM_STEP:    im_step_nxt = cfg_wdata;
        mbet_pkg::REG_ITER_LIMIT: limit_nxt   = cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end

    // Drop the result once transferred
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_a_nxt  = WORD_W'(col_clamp);
          op_b_nxt  = re_step_r;
          row_nxt   = row_clamp;
          acc_nxt   = '0;
          mstep_nxt = '0;
          job_nxt   = J_C_RE;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mstep_r != 3'd0) begin
          acc_nxt = acc_r + pp_shifted;
        end
        if (mstep_r == MSTEP_LAST) begin
          state_nxt = S_POST;
        end else begin
          mstep_nxt = mstep_r + 3'd1;
        end
      end
      S_POST: begin
        case (job_r)
          J_C_RE: begin
            c_re_nxt  = sat_word(c_re_sum);
            op_a_nxt  = WORD_W'(row_r);
            op_b_nxt  = im_step_r;
            acc_nxt   = '0;
            mstep_nxt = '0;
            job_nxt   = J_C_IM;
            state_nxt = S_MUL;
          end
          J_C_IM: begin
            c_im_nxt  = sat_word(c_im_sum);
            zr_nxt    = '0;
            zi_nxt    = '0;
            count_nxt = '0;
            red_nxt   = '0;
            state_nxt = S_CHECK;
          end
          J_SQ_RE: begin
            sq_re_nxt = sq_now;
            op_a_nxt  = zi_r;
            op_b_nxt  = zi_r;
            acc_nxt   = '0;
            mstep_nxt = '0;
            job_nxt   = J_SQ_IM;
            state_nxt = S_MUL;
          end
          J_SQ_IM: begin
            sq_im_nxt = sq_now;
            if (escaped) begin
              state_nxt = S_COLOUR;
            end else begin
              op_a_nxt  = zr_r;
              op_b_nxt  = zi_r;
              acc_nxt   = '0;
              mstep_nxt = '0;
              job_nxt   = J_CROSS;
              state_nxt = S_MUL;
            end
          end
          J_CROSS: begin
            zr_nxt    = sat_word(zr_sum);
            zi_nxt    = sat_word(zi_sum);
            count_nxt = count_r + 1'b1;
            red_nxt   = (red_r == 8'd254) ? '0 : red_r + 8'd1;
            state_nxt = S_CHECK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHECK: begin
        if (go_on) begin
          op_a_nxt  = zr_r;
          op_b_nxt  = zr_r;
          acc_nxt   = '0;
          mstep_nxt = '0;
          job_nxt   = J_SQ_RE;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_COLOUR;
        end
      end
      S_COLOUR: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {mod255(red_sq), red_r, escape_count};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    pp_r       <= pp_nxt;
    pp_sh_r    <= pp_sh_nxt;
    acc_r      <= acc_nxt;
    row_r      <= row_nxt;
    c_re_r     <= c_re_nxt;
    c_im_r     <= c_im_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    sq_re_r    <= sq_re_nxt;
    sq_im_r    <= sq_im_nxt;
    count_r    <= count_nxt;
    red_r      <= red_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= J_C_RE;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
      re_left_r   <= mbet_pkg::RE_LEFT_RST;
      im_top_r    <= mbet_pkg::IM_TOP_RST;
      re_step_r   <= mbet_pkg::RE_STEP_RST;
      im_step_r   <= mbet_pkg::IM_STEP_RST;
      limit_r     <= mbet_pkg::LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
      re_left_r   <= re_left_nxt;
      im_top_r    <= im_top_nxt;
      re_step_r   <= re_step_nxt;
      im_step_r   <= im_step_nxt;
      limit_r     <= limit_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/mbet_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbet_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mbet_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [mbet_pkg::ESC_W-1:0]  esc;
  logic [mbet_pkg::CHAN_W-1:0] red;
  logic [mbet_pkg::CHAN_W-1:0] green;

  assign esc   = out_tdata[mbet_pkg::ESC_W-1:0];
  assign red   = out_tdata[mbet_pkg::RED_LSB +: mbet_pkg::CHAN_W];
  assign green = out_tdata[mbet_pkg::GREEN_LSB +: mbet_pkg::CHAN_W];

  // A pixel keeps the core busy for at least the following cycle
  `ASSERT_NEXT(a_busy_after_transfer, in_tvalid && in_tready, !in_tready)

  // A new result is posted together with the return to idle
  `ASSERT_IMPLY(a_result_with_idle, $rose(out_tvalid), in_tready)

  // Colour channels are remainders modulo 255
  `ASSERT_IMPLY(a_channel_range, out_tvalid, red != 8'hFF && green != 8'hFF)

  // No iterations means black
  `ASSERT_IMPLY(a_zero_count_black, out_tvalid && esc == '0, red == '0 && green == '0)

  // A stalled result holds
  `ASSERT_NEXT(a_result_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind mandelbrot_escape_time_pixel_core mbet_checker u_mbet_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
